// ----- hdl/ctls_pkg.sv -----
// ----------------------------------------------------------------------------
// ctls_pkg
// Shared types, constants and register indexes for the touch lamp switch.
// ----------------------------------------------------------------------------
package ctls_pkg;

    // default averaging group size, as log2 of the sample count
    localparam int AVG_LOG2 = 2;

    // configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_TICKS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_DUTY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_DUTY   = 3'd4;

    // configuration reset values
    localparam logic [7:0] RST_WINDOW_LOW  = 8'd16;
    localparam logic [7:0] RST_WINDOW_HIGH = 8'd32;
    localparam logic [7:0] RST_CYCLE_TICKS = 8'd40;
    localparam logic [7:0] RST_HALF_DUTY   = 8'h80;
    localparam logic [7:0] RST_FULL_DUTY   = 8'hff;

    // tick counter value at which it wraps
    localparam logic [7:0] TICK_MAX = 8'd255;

    // item kinds
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    typedef struct packed {
        logic [7:0] window_low;
        logic [7:0] window_high;
        logic [7:0] cycle_ticks;
        logic [7:0] half_duty;
        logic [7:0] full_duty;
    } t_cfg;

    // one finished average from the averager
    typedef struct packed {
        logic       valid;
        logic [7:0] avg;
    } t_avg_evt;

    // one result item
    typedef struct packed {
        logic       power_enable;
        logic [7:0] duty;
        logic       half_mode;
        logic       window_open;
        logic       baseline_ready;
    } t_result;

endpackage

// ----- hdl/ctls_in_if.sv -----
// ----------------------------------------------------------------------------
// ctls_in_if
// Input channel: one sensor sample or one timer tick per transfer.
// ----------------------------------------------------------------------------
interface ctls_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] sample;

    modport source (output valid, output cmd, output sample, input ready);
    modport sink   (input valid, input cmd, input sample, output ready);
endinterface

// ----- hdl/ctls_out_if.sv -----
// ----------------------------------------------------------------------------
// ctls_out_if
// Result channel: lamp status after each item.
// ----------------------------------------------------------------------------
interface ctls_out_if;
    logic       valid;
    logic       ready;
    logic       power_enable;
    logic [7:0] duty;
    logic       half_mode;
    logic       window_open;
    logic       baseline_ready;

    modport source (output valid, output power_enable, output duty, output half_mode,
                    output window_open, output baseline_ready, input ready);
    modport sink   (input valid, input power_enable, input duty, input half_mode,
                    input window_open, input baseline_ready, output ready);
endinterface

// ----- hdl/ctls_in_stage.sv -----
// ----------------------------------------------------------------------------
// ctls_in_stage
// Input register: holds one item until the pipeline advances.
// ----------------------------------------------------------------------------
module ctls_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_cmd,
    input  logic [7:0] i_sample,
    input  logic       i_adv,
    output logic       o_ready,
    output logic       o_valid,
    output logic       o_cmd,
    output logic [7:0] o_sample
);
    logic       r_valid;
    logic       r_cmd;
    logic [7:0] r_sample;

    assign o_ready = !r_valid || i_adv;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    // payload capture on transfer
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd    <= i_cmd;
            r_sample <= i_sample;
        end
    end

    assign o_valid  = r_valid;
    assign o_cmd    = r_cmd;
    assign o_sample = r_sample;
endmodule

// ----- hdl/ctls_avg.sv -----
// ----------------------------------------------------------------------------
// ctls_avg
// Sample averager: sums groups of 2**AVG_LOG2 samples and emits the mean.
// ----------------------------------------------------------------------------
module ctls_avg #(
    parameter int AVG_LOG2 = ctls_pkg::AVG_LOG2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic               i_cmd,
    input  logic [7:0]         i_sample,
    output ctls_pkg::t_avg_evt o_evt
);
    localparam int SUM_W = 8 + AVG_LOG2;
    localparam int CNT_W = AVG_LOG2 + 1;
    localparam logic [CNT_W-1:0] GROUP = CNT_W'(2 ** AVG_LOG2);

    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] n_sum;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [SUM_W-1:0] sum_add;
    logic [CNT_W-1:0] cnt_inc;
    logic             take;
    logic             done;

    assign take    = i_fire && (i_cmd == ctls_pkg::CMD_SAMPLE);
    assign sum_add = r_sum + SUM_W'(i_sample);
    assign cnt_inc = r_cnt + CNT_W'(1);
    assign done    = (cnt_inc == GROUP);

    // accumulate and close a group
    always_comb begin
        n_sum = r_sum;
        n_cnt = r_cnt;
        if (take) begin
            n_sum = done ? '0 : sum_add;
            n_cnt = done ? '0 : cnt_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else begin
            r_sum <= n_sum;
            r_cnt <= n_cnt;
        end
    end

    assign o_evt.valid = take && done;
    assign o_evt.avg   = sum_add[AVG_LOG2 +: 8];
endmodule

// ----- hdl/ctls_ctrl.sv -----
// ----------------------------------------------------------------------------
// ctls_ctrl
// Touch detection, timing window, lamp decision and the result register.
// ----------------------------------------------------------------------------
module ctls_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic               i_adv,
    input  logic               i_cmd,
    input  ctls_pkg::t_avg_evt i_evt,
    input  ctls_pkg::t_cfg     i_cfg,
    output logic               o_valid,
    output ctls_pkg::t_result  o_res
);
    logic       r_baseline_set;
    logic [7:0] r_baseline;
    logic       r_wa;
    logic [7:0] r_tc;
    logic       r_ds;
    logic       r_pwr;
    logic       r_half;
    logic       r_en;
    logic [7:0] r_duty;

    logic       n_baseline_set;
    logic [7:0] n_baseline;
    logic       n_wa;
    logic [7:0] n_tc;
    logic       n_ds;
    logic       n_pwr;
    logic       n_half;
    logic       n_en;
    logic [7:0] n_duty;

    logic                r_out_valid;
    ctls_pkg::t_result   r_res;

    // per-item state update
    always_comb begin
        n_baseline_set = r_baseline_set;
        n_baseline     = r_baseline;
        n_wa           = r_wa;
        n_tc           = r_tc;
        n_ds           = r_ds;
        n_pwr          = r_pwr;
        n_half         = r_half;
        n_en           = r_en;
        n_duty         = r_duty;

        // averages: baseline capture or touch check
        if (i_evt.valid) begin
            if (!r_baseline_set) begin
                n_baseline     = i_evt.avg;
                n_baseline_set = (i_evt.avg != 8'd0);
            end else if ((i_evt.avg >> 1) > r_baseline) begin
                if (!r_wa) begin
                    n_wa = 1'b1;
                    n_tc = 8'd0;
                end
                if (n_tc > i_cfg.window_low && n_tc < i_cfg.window_high) begin
                    n_ds = 1'b1;
                end
            end
        end

        // timer ticks advance an open window, wrapping past the top to one
        if (i_cmd == ctls_pkg::CMD_TICK && r_wa) begin
            n_tc = (r_tc == ctls_pkg::TICK_MAX) ? 8'd1 : r_tc + 8'd1;
        end

        // end of window: lamp decision
        if (n_wa && n_tc >= i_cfg.cycle_ticks) begin
            if (!r_pwr) begin
                if (n_ds) begin
                    n_half = 1'b1;
                end
                n_pwr = 1'b1;
            end else if (!r_half && n_ds) begin
                n_half = 1'b1;
            end else begin
                n_pwr  = 1'b0;
                n_half = 1'b0;
            end
            n_wa = 1'b0;
            n_ds = 1'b0;
            n_tc = 8'd0;
        end

        // outputs follow the lamp only while no window runs
        if (!n_wa) begin
            n_en   = n_pwr;
            n_duty = n_pwr ? (n_half ? i_cfg.half_duty : i_cfg.full_duty) : 8'd0;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_baseline_set <= 1'b0;
            r_baseline     <= 8'd0;
            r_wa           <= 1'b0;
            r_tc           <= 8'd0;
            r_ds           <= 1'b0;
            r_pwr          <= 1'b0;
            r_half         <= 1'b0;
            r_en           <= 1'b0;
            r_duty         <= 8'd0;
        end else if (i_fire) begin
            r_baseline_set <= n_baseline_set;
            r_baseline     <= n_baseline;
            r_wa           <= n_wa;
            r_tc           <= n_tc;
            r_ds           <= n_ds;
            r_pwr          <= n_pwr;
            r_half         <= n_half;
            r_en           <= n_en;
            r_duty         <= n_duty;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_adv) begin
            r_out_valid <= i_fire;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_res.power_enable   <= n_en;
            r_res.duty           <= n_duty;
            r_res.half_mode      <= n_half;
            r_res.window_open    <= n_wa;
            r_res.baseline_ready <= n_baseline_set;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_res;
endmodule

// ----- hdl/capacitive_touch_lamp_switch.sv -----
// ----------------------------------------------------------------------------
// capacitive_touch_lamp_switch
// Touch sensor averaging, single/double touch timing and lamp power control.
// ----------------------------------------------------------------------------
// usage:
//   i_in carries one item per transfer: cmd 0 is a sensor sample, cmd 1 a
//   timer tick. o_out returns one status item per input item: registered
//   enable and duty, half mode flag, window flag and baseline flag.
//   registers are written via i_cfg_we / i_cfg_idx / i_cfg_data; the user
//   writes only while idle, unchecked by the block; higher indexes ignored.
// pipeline:
//   an input transfer loads the input register; the item then passes the
//   update stage into the result register, which drives o_out.valid; one
//   item per cycle sustained while o_out.ready stays high, set by the
//   single update stage between those two registers.
// reset:
//   synchronous, active low; clears averaging, baseline, window and lamp
//   state, and loads the register defaults.
// stalls:
//   when o_out.ready is low the result and input registers hold and
//   i_in.ready drops once both are full; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module capacitive_touch_lamp_switch #(
    parameter int AVG_LOG2 = ctls_pkg::AVG_LOG2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    ctls_in_if.sink                           i_in,
    ctls_out_if.source                        o_out,
    input  logic                              i_cfg_we,
    input  logic [ctls_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ctls_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    ctls_pkg::t_cfg     r_cfg;
    ctls_pkg::t_avg_evt avg_evt;
    ctls_pkg::t_result  res;
    logic               adv;
    logic               fire;
    logic               st_valid;
    logic               st_cmd;
    logic [7:0]         st_sample;
    logic               out_valid;

    // pipeline advances when the result register is free or being taken
    assign adv  = !out_valid || o_out.ready;
    assign fire = st_valid && adv;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_low  <= ctls_pkg::RST_WINDOW_LOW;
            r_cfg.window_high <= ctls_pkg::RST_WINDOW_HIGH;
            r_cfg.cycle_ticks <= ctls_pkg::RST_CYCLE_TICKS;
            r_cfg.half_duty   <= ctls_pkg::RST_HALF_DUTY;
            r_cfg.full_duty   <= ctls_pkg::RST_FULL_DUTY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ctls_pkg::CFG_WINDOW_LOW:  r_cfg.window_low  <= i_cfg_data;
                ctls_pkg::CFG_WINDOW_HIGH: r_cfg.window_high <= i_cfg_data;
                ctls_pkg::CFG_CYCLE_TICKS: r_cfg.cycle_ticks <= i_cfg_data;
                ctls_pkg::CFG_HALF_DUTY:   r_cfg.half_duty   <= i_cfg_data;
                ctls_pkg::CFG_FULL_DUTY:   r_cfg.full_duty   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ctls_in_stage u_in_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in.valid),
        .i_cmd    (i_in.cmd),
        .i_sample (i_in.sample),
        .i_adv    (adv),
        .o_ready  (i_in.ready),
        .o_valid  (st_valid),
        .o_cmd    (st_cmd),
        .o_sample (st_sample)
    );

    ctls_avg #(
        .AVG_LOG2 (AVG_LOG2)
    ) u_avg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_cmd    (st_cmd),
        .i_sample (st_sample),
        .o_evt    (avg_evt)
    );

    ctls_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_adv   (adv),
        .i_cmd   (st_cmd),
        .i_evt   (avg_evt),
        .i_cfg   (r_cfg),
        .o_valid (out_valid),
        .o_res   (res)
    );

    // result channel
    assign o_out.valid          = out_valid;
    assign o_out.power_enable   = res.power_enable;
    assign o_out.duty           = res.duty;
    assign o_out.half_mode      = res.half_mode;
    assign o_out.window_open    = res.window_open;
    assign o_out.baseline_ready = res.baseline_ready;
endmodule
